FILE: design/feature_vector_encoder_defines.svh
// Assertion macros for the feature vector encoder checker.
// Self-contained; taken in by the files that hold concurrent assertions.
`ifndef FEATURE_VECTOR_ENCODER_DEFINES_SVH
`define FEATURE_VECTOR_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FVE_ASSERT_SAME(lbl, ck, dis, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define FVE_ASSERT_NEXT(lbl, ck, dis, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/fve_pkg.sv
// Shared types, codes and constants of the feature vector encoder.
// No dependencies; every design file but the defines header refers to it by scoped names.
package fve_pkg;

  localparam int MAX_ELEMS_DEF = 64;
  localparam int VALUE_BITS    = 16;

  localparam int OP_W   = 5;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 7;
  localparam int MAX_W  = 15;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Q2.14 fixed point
  localparam int Q_SHIFT = 14;
  localparam logic [VAL_W-1:0] Q_ONE = 16'h4000;

  // quotient of v*2^14 / vmax never exceeds 2^14, so 15 bits
  localparam int Q_BITS = 15;
  localparam int DIV_W  = MAX_W + Q_SHIFT;

  // binary pattern, one spare bit for the leading flag element
  localparam int PAT_W = VAL_W + 1;
  localparam logic [VAL_W-1:0] BIN_MASK = VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

  // register map: register index sits in paddr[REG_SEL_BIT]
  localparam int   REG_SEL_BIT   = 2;
  localparam logic REG_NULL_CODE = 1'b0;
  localparam logic REG_NULL_FILL = 1'b1;
  localparam logic [VAL_W-1:0] NULL_CODE_RST = 16'hFFFF;
  localparam logic [VAL_W-1:0] NULL_FILL_RST = 16'hC000;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVER_MAX    = 2'd1,
    ST_NULL_STRICT = 2'd2,
    ST_BAD_MODE    = 2'd3
  } status_e;

  typedef enum logic [OP_W-1:0] {
    OP_BIN_EXPL     = 5'd0,
    OP_BIN_MASK     = 5'd1,
    OP_BIN_STRICT   = 5'd2,
    OP_BIN_ZERO     = 5'd3,
    OP_NORM_EXPL    = 5'd4,
    OP_NORM_MASK    = 5'd5,
    OP_NORM_STRICT  = 5'd6,
    OP_NORM_ZERO    = 5'd7,
    OP_HOT_EXPL     = 5'd8,
    OP_HOT_IMPL     = 5'd9,
    OP_HOT_MASK     = 5'd10,
    OP_HOT_STRICT   = 5'd11,
    OP_HOT_ZERO     = 5'd12,
    OP_THERM_EXPL   = 5'd13,
    OP_THERM_IMPL   = 5'd14,
    OP_THERM_MASK   = 5'd15,
    OP_THERM_STRICT = 5'd16,
    OP_THERM_ZERO   = 5'd17
  } op_e;

  // how the elements after the optional flag element are formed
  typedef enum logic [1:0] {
    BODY_CONST = 2'd0,
    BODY_BIN   = 2'd1,
    BODY_HOT   = 2'd2,
    BODY_THERM = 2'd3
  } body_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] null_code;
    logic signed [VAL_W-1:0] null_fill;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    body_e            kind;
    logic             has_head;
    logic             head_one;
    logic [PAT_W-1:0] pattern;
    logic [VAL_W-1:0] const_val;
    logic             use_quot;
  } desc_t;

endpackage

FILE: design/fve_in_if.sv
// Input channel of the feature vector encoder: one attribute per transaction.
// Depends on fve_pkg for field widths.
interface fve_in_if;
  logic                             valid;
  logic                             ready;
  logic [fve_pkg::OP_W-1:0]         op;
  logic signed [fve_pkg::VAL_W-1:0] value;
  logic [fve_pkg::CNT_W-1:0]        elem_count;
  logic [fve_pkg::MAX_W-1:0]        max_value;

  modport source (output valid, op, value, elem_count, max_value, input ready);
  modport sink (input valid, op, value, elem_count, max_value, output ready);
endinterface

FILE: design/fve_out_if.sv
// Output channel of the feature vector encoder: one element per transaction.
// Depends on fve_pkg for field widths.
interface fve_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fve_pkg::VAL_W-1:0] element;
  logic                             last;
  logic [1:0]                       status;

  modport source (output valid, element, last, status, input ready);
  modport sink (input valid, element, last, status, output ready);
endinterface

FILE: design/feature_vector_encoder.sv
// Feature vector encoder. Each attribute transaction (mode, value, element
// count, maximum) becomes a run of Q2.14 elements on the output channel, one
// element per transaction, with last set on the final one; a rejected
// attribute gives a single zero element carrying its status. The input side
// takes one attribute per cycle unless the pipeline behind it stalls; the
// output side sends one element per cycle while encoded.ready is high. The
// number of elements per attribute is the saturated element count (1 to
// MAX_ELEMS) for binary, one-hot and thermometer modes, 2 for explicit
// normalized, 1 for other normalized modes and errors. The single-element
// output port sets the sustained rate; while a long run is sent, the
// attributes behind it wait in the pipeline. An accepted attribute passes
// one decode stage, 15 divider stages (one quotient bit each), the
// serializer and the output register. Registers take effect on the
// attributes accepted after the write. Depends on fve_pkg, fve_in_if,
// fve_out_if and the fve_* submodules.
module feature_vector_encoder #(
  parameter int MAX_ELEMS = fve_pkg::MAX_ELEMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  fve_in_if.sink                      attr,
  fve_out_if.source                   encoded,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fve_pkg::ADDR_W-1:0]  paddr,
  input  logic [fve_pkg::DATA_W-1:0]  pwdata,
  output logic [fve_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int CW = $clog2(MAX_ELEMS + 1);

  fve_pkg::cfg_t              cfg;
  logic                       dec_valid;
  logic                       dec_ready;
  fve_pkg::desc_t             dec_desc;
  logic [CW-1:0]              dec_count;
  logic [CW-1:0]              dec_arg;
  logic [fve_pkg::DIV_W-1:0]  dec_rem;
  logic [fve_pkg::MAX_W-1:0]  dec_div;
  logic                       div_valid;
  logic                       div_ready;
  fve_pkg::desc_t             div_desc;
  logic [CW-1:0]              div_count;
  logic [CW-1:0]              div_arg;

  fve_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fve_decode #(
    .MAX_ELEMS (MAX_ELEMS),
    .CW        (CW)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .cfg       (cfg),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_desc  (dec_desc),
    .dec_count (dec_count),
    .dec_arg   (dec_arg),
    .dec_rem   (dec_rem),
    .dec_div   (dec_div)
  );

  fve_div_pipe #(
    .CW (CW)
  ) u_div_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_desc   (dec_desc),
    .in_count  (dec_count),
    .in_arg    (dec_arg),
    .in_rem    (dec_rem),
    .in_div    (dec_div),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_desc  (div_desc),
    .out_count (div_count),
    .out_arg   (div_arg)
  );

  fve_serializer #(
    .CW (CW)
  ) u_serializer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_ready (div_ready),
    .in_desc  (div_desc),
    .in_count (div_count),
    .in_arg   (div_arg),
    .encoded  (encoded)
  );

endmodule

FILE: design/fve_cfg_regs.sv
// APB-style register file of the feature vector encoder: null code and fill.
// Depends on fve_pkg.
module fve_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fve_pkg::ADDR_W-1:0]  paddr,
  input  logic [fve_pkg::DATA_W-1:0]  pwdata,
  output logic [fve_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output fve_pkg::cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.null_code <= fve_pkg::NULL_CODE_RST;
      cfg.null_fill <= fve_pkg::NULL_FILL_RST;
    end else if (wr) begin
      case (paddr[fve_pkg::REG_SEL_BIT])
        fve_pkg::REG_NULL_CODE: cfg.null_code <= pwdata[fve_pkg::VAL_W-1:0];
        fve_pkg::REG_NULL_FILL: cfg.null_fill <= pwdata[fve_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back sign-extended
  always_comb begin
    case (paddr[fve_pkg::REG_SEL_BIT])
      fve_pkg::REG_NULL_CODE: prdata = fve_pkg::DATA_W'(cfg.null_code);
      fve_pkg::REG_NULL_FILL: prdata = fve_pkg::DATA_W'(cfg.null_fill);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: design/fve_decode.sv
// Decode stage: error checks, mode decode, element count and the dividend
// setup for normalized modes, registered. Depends on fve_pkg and fve_in_if.
module fve_decode #(
  parameter int MAX_ELEMS = fve_pkg::MAX_ELEMS_DEF,
  parameter int CW        = $clog2(MAX_ELEMS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  fve_in_if.sink                     attr,
  input  fve_pkg::cfg_t              cfg,
  output logic                       dec_valid,
  input  logic                       dec_ready,
  output fve_pkg::desc_t             dec_desc,
  output logic [CW-1:0]              dec_count,
  output logic [CW-1:0]              dec_arg,
  output logic [fve_pkg::DIV_W-1:0]  dec_rem,
  output logic [fve_pkg::MAX_W-1:0]  dec_div
);

  logic signed [fve_pkg::VAL_W-1:0] v;
  logic signed [fve_pkg::VAL_W-1:0] vmax_s;
  logic signed [fve_pkg::VAL_W-1:0] vt;
  logic [fve_pkg::MAX_W-1:0]        vmag;
  logic [fve_pkg::MAX_W-1:0]        vtmag;
  logic                             over, bad, isnull, strict, vpos;
  logic [CW-1:0]                    n, cnt, m, arg;
  logic [fve_pkg::VAL_W-1:0]        base;
  fve_pkg::desc_t                   d;
  logic [fve_pkg::DIV_W-1:0]        rem0;

  assign attr.ready = !dec_valid || dec_ready;

  assign v      = attr.value;
  assign vmax_s = signed'({1'b0, attr.max_value});
  assign vmag   = v[fve_pkg::MAX_W-1:0];
  assign over   = v > vmax_s;
  assign bad    = attr.op > fve_pkg::OP_THERM_ZERO;
  assign isnull = v == cfg.null_code;
  assign vpos   = v > 16'sd0;
  assign strict = attr.op inside {fve_pkg::OP_BIN_STRICT, fve_pkg::OP_NORM_STRICT,
                                  fve_pkg::OP_HOT_STRICT, fve_pkg::OP_THERM_STRICT};
  assign base   = vpos ? (v & fve_pkg::BIN_MASK) : '0;

  // saturate the element count to 1..MAX_ELEMS
  always_comb begin
    if (attr.elem_count == '0) begin
      n = CW'(1);
    end else if (attr.elem_count > fve_pkg::CNT_W'(MAX_ELEMS)) begin
      n = CW'(MAX_ELEMS);
    end else begin
      n = CW'(attr.elem_count);
    end
  end

  always_comb begin
    d.status    = fve_pkg::ST_OK;
    d.kind      = fve_pkg::BODY_CONST;
    d.has_head  = 1'b0;
    d.head_one  = 1'b0;
    d.const_val = '0;
    d.use_quot  = 1'b0;
    cnt         = n;
    vt          = v;
    case (attr.op)
      fve_pkg::OP_BIN_EXPL: begin
        d.has_head = 1'b1;
        d.head_one = isnull;
        d.kind     = fve_pkg::BODY_BIN;
      end
      fve_pkg::OP_BIN_MASK: begin
        if (isnull) d.const_val = cfg.null_fill;
        else d.kind = fve_pkg::BODY_BIN;
      end
      fve_pkg::OP_BIN_STRICT, fve_pkg::OP_BIN_ZERO: begin
        d.kind = fve_pkg::BODY_BIN;
      end
      fve_pkg::OP_NORM_EXPL: begin
        d.has_head = 1'b1;
        d.head_one = isnull;
        d.use_quot = vpos;
        cnt        = CW'(2);
      end
      fve_pkg::OP_NORM_MASK: begin
        cnt = CW'(1);
        if (isnull) d.const_val = cfg.null_fill;
        else d.use_quot = vpos;
      end
      fve_pkg::OP_NORM_STRICT, fve_pkg::OP_NORM_ZERO: begin
        cnt        = CW'(1);
        d.use_quot = vpos;
      end
      fve_pkg::OP_HOT_EXPL: begin
        d.has_head = 1'b1;
        if (isnull) d.head_one = 1'b1;
        else d.kind = fve_pkg::BODY_HOT;
      end
      fve_pkg::OP_HOT_IMPL: begin
        if (!isnull) d.kind = fve_pkg::BODY_HOT;
      end
      fve_pkg::OP_HOT_MASK: begin
        if (isnull) d.const_val = cfg.null_fill;
        else d.kind = fve_pkg::BODY_HOT;
      end
      fve_pkg::OP_HOT_STRICT, fve_pkg::OP_HOT_ZERO: begin
        d.kind = fve_pkg::BODY_HOT;
      end
      fve_pkg::OP_THERM_EXPL: begin
        d.has_head = 1'b1;
        if (isnull) d.head_one = 1'b1;
        else d.kind = fve_pkg::BODY_THERM;
      end
      fve_pkg::OP_THERM_IMPL: begin
        if (!isnull) d.kind = fve_pkg::BODY_THERM;
      end
      fve_pkg::OP_THERM_MASK: begin
        if (isnull) d.const_val = cfg.null_fill;
        else d.kind = fve_pkg::BODY_THERM;
      end
      fve_pkg::OP_THERM_STRICT, fve_pkg::OP_THERM_ZERO: begin
        // zero and below still light the first element
        d.kind = fve_pkg::BODY_THERM;
        vt     = vpos ? v : '0;
      end
      default: ;
    endcase

    if (over) d.status = fve_pkg::ST_OVER_MAX;
    else if (bad) d.status = fve_pkg::ST_BAD_MODE;
    else if (isnull && strict) d.status = fve_pkg::ST_NULL_STRICT;

    // an error collapses to a single zero element
    if (d.status != fve_pkg::ST_OK) begin
      d.kind      = fve_pkg::BODY_CONST;
      d.has_head  = 1'b0;
      d.head_one  = 1'b0;
      d.const_val = '0;
      d.use_quot  = 1'b0;
      cnt         = CW'(1);
    end

    // pattern bits sit at element positions, flag included
    d.pattern = d.has_head ? {base, 1'b0} : {1'b0, base};
  end

  // index arguments are in element positions, flag included
  assign m         = cnt - CW'(d.has_head);
  assign vtmag     = vt[fve_pkg::MAX_W-1:0];

  always_comb begin
    arg = '0;
    case (d.kind)
      fve_pkg::BODY_HOT: begin
        if (!vpos) arg = CW'(d.has_head);
        else if (vmag >= fve_pkg::MAX_W'(m - CW'(1))) arg = cnt - CW'(1);
        else arg = CW'(vmag) + CW'(d.has_head);
      end
      fve_pkg::BODY_THERM: begin
        if (vt[fve_pkg::VAL_W-1]) arg = CW'(d.has_head);
        else if (vtmag >= fve_pkg::MAX_W'(m)) arg = cnt;
        else arg = CW'(vtmag) + CW'(1) + CW'(d.has_head);
      end
      default: arg = '0;
    endcase
  end

  // v * 2^14 + vmax / 2, rounding half up in the divider
  assign rem0 = fve_pkg::DIV_W'({vmag, fve_pkg::Q_SHIFT'(0)})
              + fve_pkg::DIV_W'(attr.max_value[fve_pkg::MAX_W-1:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (attr.ready) begin
      dec_valid <= attr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (attr.ready && attr.valid) begin
      dec_desc  <= d;
      dec_count <= cnt;
      dec_arg   <= arg;
      dec_rem   <= rem0;
      dec_div   <= attr.max_value;
    end
  end

endmodule

FILE: design/fve_div_pipe.sv
// Pipelined restoring divider for the normalized modes, one quotient bit per
// stage; item descriptors ride along. Depends on fve_pkg.
module fve_div_pipe #(
  parameter int CW = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fve_pkg::desc_t             in_desc,
  input  logic [CW-1:0]              in_count,
  input  logic [CW-1:0]              in_arg,
  input  logic [fve_pkg::DIV_W-1:0]  in_rem,
  input  logic [fve_pkg::MAX_W-1:0]  in_div,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fve_pkg::desc_t             out_desc,
  output logic [CW-1:0]              out_count,
  output logic [CW-1:0]              out_arg
);

  localparam int NS = fve_pkg::Q_BITS;

  logic                        vld [NS];
  logic                        rdy [NS];
  fve_pkg::desc_t              dsc [NS];
  logic [CW-1:0]               cnt [NS];
  logic [CW-1:0]               arg [NS];
  logic [fve_pkg::DIV_W-1:0]   rem [NS-1];
  logic [fve_pkg::MAX_W-1:0]   dvs [NS-1];
  logic [fve_pkg::Q_BITS-1:0]  quo [NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;

    logic                        p_vld;
    fve_pkg::desc_t              p_dsc;
    logic [CW-1:0]               p_cnt;
    logic [CW-1:0]               p_arg;
    logic [fve_pkg::DIV_W-1:0]   p_rem;
    logic [fve_pkg::MAX_W-1:0]   p_dvs;
    logic [fve_pkg::Q_BITS-1:0]  p_quo;
    logic                        nxt_rdy;
    logic [fve_pkg::DIV_W-1:0]   sub;
    logic                        fits;
    logic [fve_pkg::Q_BITS-1:0]  quo_next;

    if (s == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_dsc = in_desc;
      assign p_cnt = in_count;
      assign p_arg = in_arg;
      assign p_rem = in_rem;
      assign p_dvs = in_div;
      assign p_quo = '0;
    end else begin : g_next
      assign p_vld = vld[s-1];
      assign p_dsc = dsc[s-1];
      assign p_cnt = cnt[s-1];
      assign p_arg = arg[s-1];
      assign p_rem = rem[s-1];
      assign p_dvs = dvs[s-1];
      assign p_quo = quo[s-1];
    end

    if (s == NS - 1) begin : g_tail_rdy
      assign nxt_rdy = out_ready;
    end else begin : g_mid_rdy
      assign nxt_rdy = rdy[s+1];
    end

    assign rdy[s] = !vld[s] || nxt_rdy;
    assign sub    = fve_pkg::DIV_W'(p_dvs) << B;
    assign fits   = p_rem >= sub;

    always_comb begin
      quo_next    = p_quo;
      quo_next[B] = fits;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= p_vld;
      end
    end

    if (s < NS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (rdy[s] && p_vld) begin
          dsc[s] <= p_dsc;
          cnt[s] <= p_cnt;
          arg[s] <= p_arg;
          rem[s] <= fits ? p_rem - sub : p_rem;
          dvs[s] <= p_dvs;
          quo[s] <= quo_next;
        end
      end
    end else begin : g_last
      fve_pkg::desc_t d_next;

      // drop the finished quotient into the constant element
      always_comb begin
        d_next = p_dsc;
        if (p_dsc.use_quot) d_next.const_val = fve_pkg::VAL_W'(quo_next);
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && p_vld) begin
          dsc[s] <= d_next;
          cnt[s] <= p_cnt;
          arg[s] <= p_arg;
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];
  assign out_desc  = dsc[NS-1];
  assign out_count = cnt[NS-1];
  assign out_arg   = arg[NS-1];

endmodule

FILE: design/fve_serializer.sv
// Serializer: walks one item's elements, one per cycle unless the output
// stalls, into a registered output channel. Depends on fve_pkg and fve_out_if.
module fve_serializer #(
  parameter int CW = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fve_pkg::desc_t  in_desc,
  input  logic [CW-1:0]   in_count,
  input  logic [CW-1:0]   in_arg,
  fve_out_if.source       encoded
);

  logic                       cur_valid;
  fve_pkg::desc_t             cur_desc;
  logic [CW-1:0]              cur_count;
  logic [CW-1:0]              cur_arg;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              idx_next;
  logic                       out_load;
  logic                       emit;
  logic                       is_last;
  logic                       bin_bit;
  logic [fve_pkg::VAL_W-1:0]  elem;

  assign out_load = !encoded.valid || encoded.ready;
  assign emit     = out_load && cur_valid;
  assign is_last  = idx == cur_count - CW'(1);
  assign in_ready = !cur_valid || (emit && is_last);
  assign idx_next = idx + CW'(1);
  assign bin_bit  = |(cur_desc.pattern & (fve_pkg::PAT_W'(1) << idx));

  always_comb begin
    elem = '0;
    if (cur_desc.has_head && idx == '0) begin
      elem = cur_desc.head_one ? fve_pkg::Q_ONE : '0;
    end else begin
      case (cur_desc.kind)
        fve_pkg::BODY_CONST: elem = cur_desc.const_val;
        fve_pkg::BODY_BIN:   elem = bin_bit ? fve_pkg::Q_ONE : '0;
        fve_pkg::BODY_HOT:   elem = (idx == cur_arg) ? fve_pkg::Q_ONE : '0;
        fve_pkg::BODY_THERM: elem = (idx < cur_arg) ? fve_pkg::Q_ONE : '0;
        default:             elem = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (in_ready) begin
      cur_valid <= in_valid;
    end
  end

  // load a fresh item or advance through the current one
  always_ff @(posedge clk) begin
    if (in_ready) begin
      cur_desc  <= in_desc;
      cur_count <= in_count;
      cur_arg   <= in_arg;
      idx       <= '0;
    end else if (emit) begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoded.valid <= 1'b0;
    end else if (out_load) begin
      encoded.valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      encoded.element <= elem;
      encoded.last    <= is_last;
      encoded.status  <= cur_desc.status;
    end
  end

endmodule

FILE: design/fve_checker.sv
// Port-level checker for the feature vector encoder, bound to the top level.
// Depends on fve_pkg and feature_vector_encoder_defines.svh.
`include "feature_vector_encoder_defines.svh"

module fve_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [fve_pkg::VAL_W-1:0] out_element,
  input logic                      out_last,
  input logic [1:0]                out_status
);

  `FVE_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "output valid right after reset")

  `FVE_ASSERT_SAME(a_error_single, clk, rst, out_valid && (out_status != fve_pkg::ST_OK), out_last && (out_element == '0), "error transaction not a single zero element")

  `FVE_ASSERT_NEXT(a_valid_hold, clk, rst, out_valid && !out_ready, out_valid, "output valid dropped while stalled")

  `FVE_ASSERT_NEXT(a_payload_hold, clk, rst, out_valid && !out_ready, $stable(out_element) && $stable(out_last) && $stable(out_status), "output payload changed while stalled")

endmodule

bind feature_vector_encoder fve_checker u_fve_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (encoded.valid),
  .out_ready   (encoded.ready),
  .out_element (encoded.element),
  .out_last    (encoded.last),
  .out_status  (encoded.status)
);
